// ===== rtl/mfa_pkg.sv =====
package mfa_pkg;

  localparam int MEL_BANDS     = 30;
  localparam int SPECTRUM_BINS = 512;
  localparam int LOW_EDGE_HZ   = 0;
  localparam int HIGH_EDGE_HZ  = 8000;
  localparam int WEIGHT_BITS   = 16;

  localparam int KNEE_HZ    = 700;
  localparam int LOG_FRAC   = 28;
  localparam int BIN_W      = 24;
  localparam int SUM_W      = 48;
  localparam int BAND_OUT_W = 5;

  localparam int BAND_W     = ($clog2(MEL_BANDS) < 2) ? 2 : $clog2(MEL_BANDS);
  localparam int POS_W      = $clog2(SPECTRUM_BINS);
  localparam int ROM_W      = BAND_W + WEIGHT_BITS;
  localparam int EVEN_DEPTH = (MEL_BANDS + 1) / 2;
  localparam int ODD_DEPTH  = MEL_BANDS / 2;
  localparam int HALF_AW    = BAND_W - 1;
  localparam int WGT_W      = WEIGHT_BITS + 1;
  localparam int PROD_W     = BIN_W + WGT_W;
  localparam int ADD_W      = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [63:0]      Q32_ONE = 64'h1_0000_0000;

  typedef logic [SPECTRUM_BINS-1:0][ROM_W-1:0] rom_image_t;
  typedef logic [LOG_FRAC:0][63:0]             root_tab_t;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } mfa_state_t;

  // ---- elaboration-time table builders ----

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bv;
    logic [63:0] xx;
    res = '0;
    bv  = 64'd1 << 62;
    xx  = x;
    while (bv > xx) bv = bv >> 2;
    while (bv != 64'd0) begin
      if (xx >= res + bv) begin
        xx  = xx - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // floor(num * 2^32 / den), capped at 1.0, zero for den == 0
  function automatic logic [63:0] ratio_q32(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = num;
    if (den == 64'd0) return 64'd0;
    if (num >= den) return Q32_ONE;
    for (int b = 0; b < 32; b++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem  = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] log2_q28(input logic [63:0] x);
    logic [63:0] n;
    logic [63:0] y;
    logic [63:0] fr;
    n  = '0;
    fr = '0;
    if (x == 64'd0) return 64'd0;
    while ((x >> n) > 64'd1) n = n + 64'd1;
    y = (n <= 64'd30) ? (x << (64'd30 - n)) : (x >> (n - 64'd30));
    for (int b = 0; b < LOG_FRAC; b++) begin
      y  = (y * y) >> 30;
      fr = fr << 1;
      if (y >= (64'd2 << 30)) begin
        y     = y >> 1;
        fr[0] = 1'b1;
      end
    end
    return (n << LOG_FRAC) | fr;
  endfunction

  function automatic logic [63:0] pow2_q32(input logic [63:0] e, input root_tab_t roots);
    logic [63:0] m;
    logic [63:0] r;
    m = e >> LOG_FRAC;
    r = 64'd1 << 30;
    for (int b = 1; b <= LOG_FRAC; b++) begin
      if (e[LOG_FRAC-b]) r = (r * roots[b]) >> 30;
    end
    if (m > 64'd20) m = 64'd20;
    return (r << 2) << m;
  endfunction

  // per-bin {lower band, upper-band fraction}
  function automatic rom_image_t build_rom();
    root_tab_t                   roots;
    logic [MEL_BANDS-1:0][63:0]  v;
    logic [MEL_BANDS-1:0][63:0]  cu;
    logic [63:0]                 lhi;
    logic [63:0]                 llo;
    logic [63:0]                 mag;
    logic [63:0]                 vl;
    logic [63:0]                 p;
    logic [63:0]                 fr;
    logic                        neg;
    int                          j;
    int                          last;
    rom_image_t                  img;
    last     = MEL_BANDS - 1;
    roots[0] = 64'd2 << 30;
    for (int i = 1; i <= LOG_FRAC; i++) roots[i] = isqrt64(roots[i-1] << 30);
    lhi = log2_q28(64'(KNEE_HZ + HIGH_EDGE_HZ));
    llo = log2_q28(64'(KNEE_HZ + LOW_EDGE_HZ));
    neg = lhi < llo;
    mag = neg ? llo - lhi : lhi - llo;
    for (int i = 0; i < MEL_BANDS; i++) begin
      p    = pow2_q32((64'(i) * mag) / 64'(MEL_BANDS + 1), roots);
      v[i] = neg ? Q32_ONE - ratio_q32(Q32_ONE, p) : p - Q32_ONE;
    end
    vl = v[last];
    for (int i = 0; i < MEL_BANDS; i++) begin
      cu[i] = (vl == 64'd0) ? ratio_q32(64'(i), 64'(last)) : ratio_q32(v[i], vl);
    end
    cu[0]    = '0;
    cu[last] = Q32_ONE;
    j = 0;
    for (int k = 0; k < SPECTRUM_BINS; k++) begin
      p = ratio_q32(64'(k), 64'(SPECTRUM_BINS));
      while (j < last - 1 && cu[j+1] <= p) j++;
      fr     = ratio_q32(p - cu[j], cu[j+1] - cu[j]) >> (32 - WEIGHT_BITS);
      img[k] = {BAND_W'(j), WEIGHT_BITS'(fr)};
    end
    return img;
  endfunction

  localparam rom_image_t BIN_ROM = build_rom();

endpackage

// ===== rtl/mfa_sum_ram.sv =====
module mfa_sum_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a same-cycle write is not seen by the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mel_filterbank_accumulator_unit.sv =====
// channel | dir | handshake              | payload
// bin     | in  | bin_valid / bin_stall  | bin_value[23:0], frame_start
// band    | out | band_valid / band_stall | band_index[4:0], band_energy[47:0], last_band
//
// One bin per cycle inside a frame; three-stage pipe: ROM read, RAM read, add/write.
// Band sums sit in two RAMs (even and odd bands) so a bin updates both neighbours at once.
// After the last bin, input stalls while the pipe empties and the sums are read out (longer
// under band_stall), and until the last band request is taken.
// Synchronous reset clears control and the per-entry valid bits; no RAM sweep needed.
module mel_filterbank_accumulator_unit
  import mfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  bin_valid,
  output logic                  bin_stall,
  input  logic [BIN_W-1:0]      bin_value,
  input  logic                  frame_start,
  output logic                  band_valid,
  input  logic                  band_stall,
  output logic [BAND_OUT_W-1:0] band_index,
  output logic [SUM_W-1:0]      band_energy,
  output logic                  last_band
);

  logic                  accept;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      cur_pos;
  logic                  pos_end;

  logic                  s1_vld;
  logic                  s1_fs;
  logic                  s1_end;
  logic [BIN_W-1:0]      s1_bin;
  logic [ROM_W-1:0]      rom_q;
  logic [BAND_W-1:0]     s1_band;
  logic [BAND_W-1:0]     s1_band_hi;
  logic [WEIGHT_BITS-1:0] s1_frac;
  logic [WGT_W-1:0]      w_lo;
  logic [PROD_W-1:0]     prod_lo;
  logic [PROD_W-1:0]     prod_hi;
  logic [HALF_AW-1:0]    s1_e_addr;
  logic [HALF_AW-1:0]    s1_o_addr;

  logic                  s2_vld;
  logic                  s2_fs;
  logic                  s2_end;
  logic [HALF_AW-1:0]    s2_e_addr;
  logic [HALF_AW-1:0]    s2_o_addr;
  logic [PROD_W-1:0]     s2_e_prod;
  logic [PROD_W-1:0]     s2_o_prod;
  logic [SUM_W-1:0]      e_old;
  logic [SUM_W-1:0]      o_old;
  logic [ADD_W-1:0]      e_sum;
  logic [ADD_W-1:0]      o_sum;
  logic [SUM_W-1:0]      e_new;
  logic [SUM_W-1:0]      o_new;

  logic                  wb_vld;
  logic [HALF_AW-1:0]    wb_e_addr;
  logic [HALF_AW-1:0]    wb_o_addr;
  logic [SUM_W-1:0]      wb_e_data;
  logic [SUM_W-1:0]      wb_o_data;

  logic [EVEN_DEPTH-1:0] ev_vld;
  logic [EVEN_DEPTH-1:0] ev_vld_next;
  logic [ODD_DEPTH-1:0]  od_vld;
  logic [ODD_DEPTH-1:0]  od_vld_next;

  logic                  re;
  logic [HALF_AW-1:0]    e_raddr;
  logic [HALF_AW-1:0]    o_raddr;
  logic [SUM_W-1:0]      e_rd;
  logic [SUM_W-1:0]      o_rd;

  mfa_state_t            state;
  mfa_state_t            state_next;
  logic [BAND_W-1:0]     drain_idx;
  logic [HALF_AW-1:0]    drain_addr;
  logic                  drain_issue;
  logic                  drain_last;
  logic [BAND_W-1:0]     out_band;
  logic                  out_par;
  logic                  out_ent;

  // ---- stage 0: bin counter and ROM read ----
  assign accept    = bin_valid && !bin_stall;
  assign cur_pos   = frame_start ? '0 : pos;
  assign pos_end   = cur_pos == POS_W'(SPECTRUM_BINS - 1);
  assign bin_stall = (state != ST_RUN) || (s1_vld && s1_end) || (s2_vld && s2_end) ||
                     band_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
      if (accept) begin
        pos <= pos_end ? '0 : cur_pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rom_q  <= BIN_ROM[cur_pos];
      s1_bin <= bin_value;
      s1_fs  <= frame_start;
      s1_end <= pos_end;
    end
  end

  // ---- stage 1: weights, products, RAM read ----
  assign s1_band    = rom_q[ROM_W-1:WEIGHT_BITS];
  assign s1_frac    = rom_q[WEIGHT_BITS-1:0];
  assign s1_band_hi = s1_band + BAND_W'(1);
  assign w_lo       = WGT_W'(1 << WEIGHT_BITS) - WGT_W'(s1_frac);
  assign prod_lo    = PROD_W'(s1_bin) * PROD_W'(w_lo);
  assign prod_hi    = PROD_W'(s1_bin) * PROD_W'(s1_frac);

  // lower band and upper band always have opposite parity
  assign s1_e_addr = s1_band[0] ? s1_band_hi[BAND_W-1:1] : s1_band[BAND_W-1:1];
  assign s1_o_addr = s1_band[0] ? s1_band[BAND_W-1:1] : s1_band_hi[BAND_W-1:1];

  assign drain_addr = drain_idx[BAND_W-1:1];
  assign re         = s1_vld || drain_issue;
  assign e_raddr    = (state == ST_DRAIN) ? drain_addr : s1_e_addr;
  assign o_raddr    = (state == ST_DRAIN) ? drain_addr : s1_o_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      s2_fs     <= s1_fs;
      s2_end    <= s1_end;
      s2_e_addr <= s1_e_addr;
      s2_o_addr <= s1_o_addr;
      s2_e_prod <= s1_band[0] ? prod_hi : prod_lo;
      s2_o_prod <= s1_band[0] ? prod_lo : prod_hi;
    end
  end

  // ---- stage 2: forward, saturating add, write back ----
  always_comb begin
    if (s2_fs) begin
      e_old = '0;
    end else if (wb_vld && wb_e_addr == s2_e_addr) begin
      e_old = wb_e_data;
    end else begin
      e_old = ev_vld[s2_e_addr] ? e_rd : '0;
    end
    if (s2_fs) begin
      o_old = '0;
    end else if (wb_vld && wb_o_addr == s2_o_addr) begin
      o_old = wb_o_data;
    end else begin
      o_old = od_vld[s2_o_addr] ? o_rd : '0;
    end
  end

  assign e_sum = ADD_W'(e_old) + ADD_W'(s2_e_prod);
  assign o_sum = ADD_W'(o_old) + ADD_W'(s2_o_prod);
  assign e_new = (e_sum > ADD_W'(SUM_MAX)) ? SUM_MAX : e_sum[SUM_W-1:0];
  assign o_new = (o_sum > ADD_W'(SUM_MAX)) ? SUM_MAX : o_sum[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_vld <= 1'b0;
    end else begin
      wb_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld) begin
      wb_e_addr <= s2_e_addr;
      wb_o_addr <= s2_o_addr;
      wb_e_data <= e_new;
      wb_o_data <= o_new;
    end
  end

  // entries not written since the last clear read as zero
  always_comb begin
    ev_vld_next = ev_vld;
    od_vld_next = od_vld;
    if (s2_vld) begin
      if (s2_fs) begin
        ev_vld_next = '0;
        od_vld_next = '0;
      end
      ev_vld_next[s2_e_addr] = 1'b1;
      od_vld_next[s2_o_addr] = 1'b1;
    end
    if (drain_issue && drain_last) begin
      ev_vld_next = '0;
      od_vld_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_vld <= '0;
      od_vld <= '0;
    end else begin
      ev_vld <= ev_vld_next;
      od_vld <= od_vld_next;
    end
  end

  mfa_sum_ram #(
    .DEPTH (EVEN_DEPTH),
    .WIDTH (SUM_W),
    .AW    (HALF_AW)
  ) u_even_ram (
    .clk   (clk),
    .we    (s2_vld),
    .waddr (s2_e_addr),
    .wdata (e_new),
    .re    (re),
    .raddr (e_raddr),
    .rdata (e_rd)
  );

  mfa_sum_ram #(
    .DEPTH (ODD_DEPTH),
    .WIDTH (SUM_W),
    .AW    (HALF_AW)
  ) u_odd_ram (
    .clk   (clk),
    .we    (s2_vld),
    .waddr (s2_o_addr),
    .wdata (o_new),
    .re    (re),
    .raddr (o_raddr),
    .rdata (o_rd)
  );

  // ---- readout sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      drain_idx <= '0;
    end else begin
      state <= state_next;
      if (drain_issue) begin
        drain_idx <= drain_last ? '0 : drain_idx + BAND_W'(1);
      end
    end
  end

  always_comb begin
    state_next  = state;
    drain_last  = drain_idx == BAND_W'(MEL_BANDS - 1);
    drain_issue = 1'b0;
    case (state)
      ST_RUN: begin
        if (s2_vld && s2_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_issue = !band_valid || !band_stall;
        if (drain_issue && drain_last) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // output request: RAM read data holds while no new read is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      band_valid <= 1'b0;
    end else if (drain_issue) begin
      band_valid <= 1'b1;
    end else if (!band_stall) begin
      band_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_issue) begin
      out_band  <= drain_idx;
      out_par   <= drain_idx[0];
      out_ent   <= drain_idx[0] ? od_vld[drain_addr] : ev_vld[drain_addr];
      last_band <= drain_last;
    end
  end

  assign band_index  = BAND_OUT_W'(out_band);
  assign band_energy = out_ent ? (out_par ? o_rd : e_rd) : '0;

endmodule

// ===== rtl/mfa_checker.sv =====
module mfa_checker
  import mfa_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  bin_valid,
  input logic                  bin_stall,
  input logic [BIN_W-1:0]      bin_value,
  input logic                  frame_start,
  input logic                  band_valid,
  input logic                  band_stall,
  input logic [BAND_OUT_W-1:0] band_index,
  input logic [SUM_W-1:0]      band_energy,
  input logic                  last_band
);

  // the final request of a run always names the top band
  a_last_is_top: assert property (@(posedge clk) disable iff (rst)
    band_valid && last_band |-> band_index == BAND_OUT_W'(MEL_BANDS - 1))
    else $error("last_band on wrong band_index");

  // bands come out in ascending order
  a_band_order: assert property (@(posedge clk) disable iff (rst)
    band_valid && !band_stall && !last_band |=>
      !band_valid || band_index == BAND_OUT_W'($past(band_index) + BAND_OUT_W'(1)))
    else $error("band_index out of sequence");

  // nothing follows the last band until another frame completes
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    band_valid && !band_stall && last_band |=> !band_valid)
    else $error("result right after last band");

  // no bin is taken while results are pending
  a_no_bin_during_readout: assert property (@(posedge clk) disable iff (rst)
    band_valid |-> bin_stall)
    else $error("bin accepted during readout");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    band_valid && band_stall |=>
      band_valid && $stable(band_index) && $stable(band_energy) && $stable(last_band))
    else $error("stalled result changed");

endmodule

bind mel_filterbank_accumulator_unit mfa_checker u_mfa_checker (.*);
